@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the bit reader.
// No dependencies; each user supplies clk and rst_n in its own scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/jub_pkg.sv @@
// Package for the JPEG unstuffing bit reader: codes, widths and the result type.
// No dependencies.
package jub_pkg;

  localparam int STORE_BITS = 24;
  localparam int HELD_W     = 5;
  localparam int VALUE_W    = 16;

  localparam logic [7:0] STUFF_MARK = 8'hFF;
  localparam logic [7:0] STUFF_BYTE = 8'h00;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_REQ  = 2'd1,
    MODE_EOS  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_NO_BITS   = 2'd3
  } status_t;

  typedef struct packed {
    logic [VALUE_W-1:0] field_value;
    logic               lead_bit;
    status_t            status;
  } res_t;

endpackage

@@ hw/rtl/jpeg_unstuff_bit_reader_core.sv @@
// JPEG entropy bit reader with 0xFF00 byte unstuffing.
// Depends on jub_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall): each item carries in_mode, in_data_byte
//   and in_bit_count. Mode push appends a byte to a 24-bit bit store (a 0x00
//   after a kept 0xFF is dropped), mode request reads 0..min(MAX_FIELD_BITS,24)
//   bits MSB first, mode end-of-stream fails a held request, mode 3 does nothing.
//   Result channel (out_valid / out_stall): zero or one result per item with
//   out_field_value, out_lead_bit and out_status.
//   A result is registered in the output entry (or the skid entry). A request
//   that finds too few bits is held and answered by the push that fills it.
//   Throughput: one item per cycle unless stalled; the step (unstuff, append,
//   barrel shift extract) is one combinational pass from the state registers.
//   Stall: the result register is backed by one skid entry. When the receiver
//   stalls and a second result is produced, it waits in the skid entry and
//   in_stall rises until the skid entry drains.
//   Reset: synchronous, active low; the bit store, pending request, stuffing
//   flag and the valid flags of both output entries are cleared.
module jpeg_unstuff_bit_reader_core #(
  parameter int MAX_FIELD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [7:0]                    in_data_byte,
  input  logic [4:0]                    in_bit_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [jub_pkg::VALUE_W-1:0]   out_field_value,
  output logic                          out_lead_bit,
  output logic [1:0]                    out_status
);
  import jub_pkg::*;

  // Largest legal request: bounded by the parameter and by the store size
  localparam int CountLimit = (MAX_FIELD_BITS < STORE_BITS) ? MAX_FIELD_BITS : STORE_BITS;
  localparam logic [5:0] CountLimitW = 6'(CountLimit);
  localparam logic [HELD_W-1:0] PushMaxHeld = HELD_W'(STORE_BITS - 8);

  // State
  logic [STORE_BITS-1:0] store_r, store_nxt;
  logic [HELD_W-1:0]     held_r, held_nxt;
  logic                  ff_r, ff_nxt;
  logic                  pend_r, pend_nxt;
  logic [HELD_W-1:0]     pcnt_r, pcnt_nxt;

  // Output entry and skid entry
  res_t out_r, out_nxt;
  logic out_vld_r, out_vld_nxt;
  res_t skid_r, skid_nxt;
  logic skid_vld_r, skid_vld_nxt;

  logic in_fire;
  logic out_fire;
  logic res_vld;
  res_t res;

  // Store after a push
  logic [STORE_BITS-1:0] store_p;
  logic [HELD_W-1:0]     held_p;
  logic                  stuffed;

  // Shared extract unit
  logic [STORE_BITS-1:0] tk_store;
  logic [HELD_W-1:0]     tk_held;
  logic [HELD_W-1:0]     tk_cnt;
  logic [HELD_W-1:0]     tk_shift;
  logic [HELD_W-1:0]     tk_first_idx;
  logic [STORE_BITS-1:0] tk_shifted;
  logic [STORE_BITS:0]   tk_vmask;
  logic [STORE_BITS:0]   tk_kmask;
  logic [STORE_BITS-1:0] tk_val;
  logic [STORE_BITS-1:0] tk_rest;
  logic                  tk_first;

  assign in_stall = skid_vld_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_vld_r && !out_stall;

  assign out_valid       = out_vld_r;
  assign out_field_value = out_r.field_value;
  assign out_lead_bit    = out_r.lead_bit;
  assign out_status      = out_r.status;

  // Push path: drop stuffing byte, append kept byte
  assign stuffed = ff_r && (in_data_byte == STUFF_BYTE);
  assign store_p = {store_r[STORE_BITS-9:0], in_data_byte};
  assign held_p  = held_r + HELD_W'(8);

  // Extract operands: a push serves the held request, a request reads directly
  always_comb begin
    if (in_mode == MODE_PUSH) begin
      tk_store = store_p;
      tk_held  = held_p;
      tk_cnt   = pcnt_r;
    end else begin
      tk_store = store_r;
      tk_held  = held_r;
      tk_cnt   = in_bit_count;
    end
  end

  // Barrel shift extract, MSB first
  assign tk_shift     = tk_held - tk_cnt;
  assign tk_first_idx = tk_held - HELD_W'(1);
  assign tk_shifted   = tk_store >> tk_shift;
  assign tk_vmask     = ((STORE_BITS+1)'(1) << tk_cnt) - (STORE_BITS+1)'(1);
  assign tk_kmask     = ((STORE_BITS+1)'(1) << tk_shift) - (STORE_BITS+1)'(1);
  assign tk_val       = tk_shifted & tk_vmask[STORE_BITS-1:0];
  assign tk_rest      = tk_store & tk_kmask[STORE_BITS-1:0];
  assign tk_first     = tk_store[tk_first_idx];

  // Step logic
  always_comb begin
    store_nxt = store_r;
    held_nxt  = held_r;
    ff_nxt    = ff_r;
    pend_nxt  = pend_r;
    pcnt_nxt  = pcnt_r;
    res_vld   = 1'b0;
    res       = '{field_value: '0, lead_bit: 1'b0, status: ST_OK};
    if (in_fire) begin
      unique case (in_mode)
        MODE_PUSH: begin
          if (stuffed) begin
            ff_nxt = 1'b0;
          end else if (held_r > PushMaxHeld) begin
            res_vld    = 1'b1;
            res.status = ST_FULL;
          end else begin
            ff_nxt = (in_data_byte == STUFF_MARK);
            if (pend_r && held_p >= pcnt_r) begin
              pend_nxt        = 1'b0;
              store_nxt       = tk_rest;
              held_nxt        = tk_shift;
              res_vld         = 1'b1;
              res.field_value = tk_val[VALUE_W-1:0];
              res.lead_bit    = tk_first;
            end else begin
              store_nxt = store_p;
              held_nxt  = held_p;
            end
          end
        end
        MODE_REQ: begin
          if ({1'b0, in_bit_count} > CountLimitW) begin
            res_vld    = 1'b1;
            res.status = ST_BAD_COUNT;
          end else begin
            pend_nxt = 1'b0;
            if (in_bit_count == '0) begin
              res_vld      = 1'b1;
              res.lead_bit = 1'b1;
            end else if (held_r >= in_bit_count) begin
              store_nxt       = tk_rest;
              held_nxt        = tk_shift;
              res_vld         = 1'b1;
              res.field_value = tk_val[VALUE_W-1:0];
              res.lead_bit    = tk_first;
            end else begin
              pend_nxt = 1'b1;
              pcnt_nxt = in_bit_count;
            end
          end
        end
        MODE_EOS: begin
          if (pend_r) begin
            pend_nxt   = 1'b0;
            res_vld    = 1'b1;
            res.status = ST_NO_BITS;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output entry with skid entry behind it
  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (!out_vld_r || out_fire) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        out_nxt     = res;
        out_vld_nxt = res_vld;
      end
    end else if (res_vld) begin
      skid_nxt     = res;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r    <= '0;
      held_r     <= '0;
      ff_r       <= 1'b0;
      pend_r     <= 1'b0;
      pcnt_r     <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      store_r    <= store_nxt;
      held_r     <= held_nxt;
      ff_r       <= ff_nxt;
      pend_r     <= pend_nxt;
      pcnt_r     <= pcnt_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // Checks
`include "assert_macros.svh"
  `ASSERT_IMPL(a_held_max, 1'b1, held_r <= HELD_W'(STORE_BITS))
  `ASSERT_IMPL(a_pend_short, pend_r, held_r < pcnt_r)
  `ASSERT_IMPL(a_pend_legal, pend_r, (pcnt_r != '0) && ({1'b0, pcnt_r} <= CountLimitW))
  `ASSERT_IMPL(a_skid_behind_out, skid_vld_r, out_vld_r)
  `ASSERT_NEXT(a_skid_fill, out_vld_r && out_stall && res_vld, skid_vld_r)

endmodule
